FILE: rtl/aarc_pkg.sv
// ----------------------------------------------------------------------------
// aarc_pkg
// Shared types of the ring-and-dot pixel compositor.
// ----------------------------------------------------------------------------
package aarc_pkg;

   // One straight-alpha pixel.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } px_type;

   // Geometry and colour of one shape as seen by a blend pipeline.
   // mid2 is twice the centre of the edge ramp, in units of 2^-G pixel.
   typedef struct packed {
      logic        enable;
      logic [15:0] radius;
      logic [16:0] mid2;
      logic [31:0] color;
   } shape_cfg_type;

endpackage

FILE: rtl/aarc_if.sv
// ----------------------------------------------------------------------------
// aarc_req_if / aarc_rsp_if
// Valid/ready channels of the compositor: input pixels and composited pixels.
// ----------------------------------------------------------------------------
interface aarc_req_if #(
   parameter int COORD_WIDTH = 10
) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] pixel_x;
   logic [COORD_WIDTH-1:0] pixel_y;
   logic [7:0]             dst_blue;
   logic [7:0]             dst_green;
   logic [7:0]             dst_red;
   logic [7:0]             dst_alpha;

   modport source (
      output valid, pixel_x, pixel_y, dst_blue, dst_green, dst_red, dst_alpha,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, dst_blue, dst_green, dst_red, dst_alpha,
      output ready
   );
endinterface

interface aarc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic [7:0] out_alpha;

   modport source (
      output valid, out_blue, out_green, out_red, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_blue, out_green, out_red, out_alpha,
      output ready
   );
endinterface

FILE: rtl/aa_ring_dot_pixel_compositor.sv
// ----------------------------------------------------------------------------
// aa_ring_dot_pixel_compositor
// Antialiased outer ring, inner ring and dot composited over a BGRA pixel.
// ----------------------------------------------------------------------------
//  channel  direction  transfer / write
//  req_if   in         pixel_x, pixel_y, dst_blue, dst_green, dst_red, dst_alpha
//  rsp_if   out        out_blue, out_green, out_red, out_alpha
//  csr_*    in         csr_we, csr_index, csr_wdata (no read-back)
//
// One pixel is accepted every cycle unless a result waits on rsp_if. The
// input register, offset, square and radicand stages lead into the square root
// pipeline (one result bit a stage) and three blend pipelines of 16 stages,
// each with a nine-stage restoring divider. The whole pipeline halts while a
// result waits on rsp_if; nothing is dropped or repeated. Reset clears the
// valid bits and the configuration registers.
module aa_ring_dot_pixel_compositor
   import aarc_pkg::*;
#(
   parameter int COORD_WIDTH    = 10,
   parameter int GEOM_FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   aarc_req_if.sink     req_if,
   aarc_rsp_if.source   rsp_if,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [32:0]  csr_wdata
);

   localparam int HW     = COORD_WIDTH + 2;
   localparam int SQ_W   = 2 * COORD_WIDTH + 2;
   localparam int DIST_W = COORD_WIDTH + GEOM_FRAC_BITS + 1;
   localparam int RAD_W  = 2 * DIST_W;
   localparam int REM_W  = DIST_W + 3;

   localparam logic [2:0] CSR_CENTER_X    = 3'd0;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd1;
   localparam logic [2:0] CSR_OUTER_SHAPE = 3'd2;
   localparam logic [2:0] CSR_OUTER_COLOR = 3'd3;
   localparam logic [2:0] CSR_INNER_SHAPE = 3'd4;
   localparam logic [2:0] CSR_INNER_COLOR = 3'd5;
   localparam logic [2:0] CSR_DOT_SHAPE   = 3'd6;
   localparam logic [2:0] CSR_DOT_COLOR   = 3'd7;

   // ---------------- configuration registers ----------------
   logic [9:0]  center_x_ff, center_y_ff;
   logic [32:0] outer_shape_ff, inner_shape_ff;
   logic [31:0] outer_color_ff, inner_color_ff, dot_color_ff;
   logic [16:0] dot_shape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         outer_shape_ff <= '0;
         outer_color_ff <= '0;
         inner_shape_ff <= '0;
         inner_color_ff <= '0;
         dot_shape_ff   <= '0;
         dot_color_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:    center_x_ff    <= csr_wdata[9:0];
            CSR_CENTER_Y:    center_y_ff    <= csr_wdata[9:0];
            CSR_OUTER_SHAPE: outer_shape_ff <= csr_wdata;
            CSR_OUTER_COLOR: outer_color_ff <= csr_wdata[31:0];
            CSR_INNER_SHAPE: inner_shape_ff <= csr_wdata;
            CSR_INNER_COLOR: inner_color_ff <= csr_wdata[31:0];
            CSR_DOT_SHAPE:   dot_shape_ff   <= csr_wdata[16:0];
            CSR_DOT_COLOR:   dot_color_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   shape_cfg_type outer_cfg, inner_cfg, dot_cfg;

   always_comb begin
      outer_cfg.enable = outer_shape_ff[32];
      outer_cfg.radius = outer_shape_ff[31:16];
      outer_cfg.mid2   = {1'b0, outer_shape_ff[15:0]};
      outer_cfg.color  = outer_color_ff;
      inner_cfg.enable = inner_shape_ff[32];
      inner_cfg.radius = inner_shape_ff[31:16];
      inner_cfg.mid2   = {1'b0, inner_shape_ff[15:0]};
      inner_cfg.color  = inner_color_ff;
      // A zero radius makes the ring distance the plain distance.
      dot_cfg.enable   = dot_shape_ff[16];
      dot_cfg.radius   = '0;
      dot_cfg.mid2     = {dot_shape_ff[15:0], 1'b0};
      dot_cfg.color    = dot_color_ff;
   end

   logic adv;
   logic b1_valid, b2_valid, b3_valid;
   logic [DIST_W-1:0] b1_dist, b2_dist;
   px_type b1_px, b2_px, b3_px;

   assign adv          = !b3_valid || rsp_if.ready;
   assign req_if.ready = adv;

   // ---------------- stage 0: input register ----------------
   logic                   in_valid_ff;
   logic [COORD_WIDTH-1:0] in_x_ff, in_y_ff;
   px_type                 in_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_x_ff        <= req_if.pixel_x;
         in_y_ff        <= req_if.pixel_y;
         in_px_ff.blue  <= req_if.dst_blue;
         in_px_ff.green <= req_if.dst_green;
         in_px_ff.red   <= req_if.dst_red;
         in_px_ff.alpha <= req_if.dst_alpha;
      end
   end

   // ---------------- stage 1: offsets in half pixels ----------------
   logic                 h_valid_ff;
   logic signed [HW-1:0] h_x_ff, h_y_ff;
   px_type               h_px_ff;
   logic signed [HW-1:0] hx_in, hy_in;

   always_comb begin
      hx_in = ((signed'(HW'(in_x_ff)) - signed'(HW'(COORD_WIDTH'(center_x_ff)))) <<< 1)
              + HW'(1);
      hy_in = ((signed'(HW'(in_y_ff)) - signed'(HW'(COORD_WIDTH'(center_y_ff)))) <<< 1)
              + HW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_x_ff  <= hx_in;
         h_y_ff  <= hy_in;
         h_px_ff <= in_px_ff;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic                  s_valid_ff;
   logic [SQ_W-1:0]       s_x_ff, s_y_ff;
   px_type                s_px_ff;
   logic signed [2*HW-1:0] sqx_in, sqy_in;

   always_comb begin
      sqx_in = h_x_ff * h_x_ff;
      sqy_in = h_y_ff * h_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_x_ff  <= sqx_in[SQ_W-1:0];
         s_y_ff  <= sqy_in[SQ_W-1:0];
         s_px_ff <= h_px_ff;
      end
   end

   // ---------------- stage 3 and square root pipeline ----------------
   typedef struct packed {
      px_type             px;
      logic [RAD_W-1:0]   rad;
      logic [REM_W-1:0]   rem;
      logic [DIST_W-1:0]  root;
   } sq_type;

   sq_type            sq_ff [0:DIST_W];
   logic [DIST_W:0]   sq_valid_ff;
   sq_type            rad_in;

   always_comb begin
      rad_in.px   = s_px_ff;
      rad_in.rad  = RAD_W'(RAD_W'(s_x_ff) + RAD_W'(s_y_ff)) << (2 * GEOM_FRAC_BITS - 2);
      rad_in.rem  = '0;
      rad_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_valid_ff[0] <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0] <= rad_in;
      end
   end

   for (genvar k = 0; k < DIST_W; k++) begin : g_sqrt
      localparam int HI = RAD_W - 1 - 2 * k;
      sq_type            step_in;
      logic [REM_W-1:0]  rem_sh, trial;

      always_comb begin
         rem_sh  = {sq_ff[k].rem[REM_W-3:0], sq_ff[k].rad[HI -: 2]};
         trial   = {1'b0, sq_ff[k].root, 2'b01};
         step_in = sq_ff[k];
         if (rem_sh >= trial) begin
            step_in.rem  = rem_sh - trial;
            step_in.root = {sq_ff[k].root[DIST_W-2:0], 1'b1};
         end else begin
            step_in.rem  = rem_sh;
            step_in.root = {sq_ff[k].root[DIST_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k+1] <= step_in;
         end
      end
   end

   // ---------------- three blends in order ----------------
   aarc_blend #(
      .DIST_W         (DIST_W),
      .GEOM_FRAC_BITS (GEOM_FRAC_BITS)
   ) u_outer (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (outer_cfg),
      .in_valid  (sq_valid_ff[DIST_W]),
      .in_dist   (sq_ff[DIST_W].root),
      .in_px     (sq_ff[DIST_W].px),
      .out_valid (b1_valid),
      .out_dist  (b1_dist),
      .out_px    (b1_px)
   );

   aarc_blend #(
      .DIST_W         (DIST_W),
      .GEOM_FRAC_BITS (GEOM_FRAC_BITS)
   ) u_inner (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (inner_cfg),
      .in_valid  (b1_valid),
      .in_dist   (b1_dist),
      .in_px     (b1_px),
      .out_valid (b2_valid),
      .out_dist  (b2_dist),
      .out_px    (b2_px)
   );

   aarc_blend #(
      .DIST_W         (DIST_W),
      .GEOM_FRAC_BITS (GEOM_FRAC_BITS)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (dot_cfg),
      .in_valid  (b2_valid),
      .in_dist   (b2_dist),
      .in_px     (b2_px),
      .out_valid (b3_valid),
      .out_dist  (),
      .out_px    (b3_px)
   );

   assign rsp_if.valid     = b3_valid;
   assign rsp_if.out_blue  = b3_px.blue;
   assign rsp_if.out_green = b3_px.green;
   assign rsp_if.out_red   = b3_px.red;
   assign rsp_if.out_alpha = b3_px.alpha;

   // ---------------- checks ----------------
   logic [RAD_W+1:0] root_sq_chk, root1_sq_chk;

   assign root_sq_chk  = (RAD_W+2)'(sq_ff[DIST_W].root) * (RAD_W+2)'(sq_ff[DIST_W].root);
   assign root1_sq_chk = ((RAD_W+2)'(sq_ff[DIST_W].root) + (RAD_W+2)'(1))
                         * ((RAD_W+2)'(sq_ff[DIST_W].root) + (RAD_W+2)'(1));

   // The square root pipeline returns the floor of the root.
   a_sqrt_floor: assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff[DIST_W] |->
         root_sq_chk <= (RAD_W+2)'(sq_ff[DIST_W].rad)
         && root1_sq_chk > (RAD_W+2)'(sq_ff[DIST_W].rad))
      else $error("aarc: square root result is not the floor root");

   // A stall freezes the radicand stage.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(sq_valid_ff[0]) && $stable(sq_ff[0]))
      else $error("aarc: radicand stage changed during a stall");

   // A pixel in the input register reaches the offset stage on advance.
   a_in_moves: assert property (@(posedge clock) disable iff (reset)
      adv && in_valid_ff |=> h_valid_ff)
      else $error("aarc: pixel lost between input and offset stage");

endmodule

FILE: rtl/aarc_blend.sv
// ----------------------------------------------------------------------------
// aarc_blend
// Coverage of one shape from the centre distance, then straight-alpha over
// blending of the shape colour onto the pixel. Fixed 16-stage pipeline.
// ----------------------------------------------------------------------------
module aarc_blend
   import aarc_pkg::*;
#(
   parameter int DIST_W         = 19,
   parameter int GEOM_FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  shape_cfg_type       cfg,
   input  logic                in_valid,
   input  logic [DIST_W-1:0]   in_dist,
   input  px_type              in_px,
   output logic                out_valid,
   output logic [DIST_W-1:0]   out_dist,
   output px_type              out_px
);

   localparam int MAG_W  = (DIST_W > 16) ? DIST_W : 16;
   localparam int SW     = MAG_W + 3;
   localparam int RW     = SW + 9;
   localparam int ONE_FX = 1 << GEOM_FRAC_BITS;
   localparam int NUM_W  = 26;
   localparam int QW     = 9;
   localparam logic [15:0] RECIP_255 = 16'd32897;

   typedef struct packed {
      px_type                 px;
      logic [DIST_W-1:0]      rdist;
      logic                   skip;
      logic [7:0]             oa;
      logic [16:0]            den2;
      logic [2:0][NUM_W-1:0]  rem;
      logic [2:0][QW-1:0]     quo;
   } div_type;

   // ---------------- stage A: distance from the ramp centre ----------------
   logic                    a_valid_ff;
   logic [DIST_W-1:0]       a_dist_ff;
   px_type                  a_px_ff;
   logic signed [SW-1:0]    a_s2_ff;
   logic signed [SW-1:0]    diff_in, s2_in;

   always_comb begin
      diff_in = signed'(SW'(in_dist)) - signed'(SW'(cfg.radius));
      s2_in   = ((diff_in < 0) ? -diff_in : diff_in) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dist_ff <= in_dist;
         a_px_ff   <= in_px;
         a_s2_ff   <= s2_in;
      end
   end

   // ---------------- stage B: coverage ----------------
   logic                    b_valid_ff;
   logic [DIST_W-1:0]       b_dist_ff;
   px_type                  b_px_ff;
   logic [7:0]              b_cov_ff;
   logic signed [SW-1:0]    mid_s, e0, e1;
   logic signed [RW-1:0]    ramp, ramp255;
   logic [7:0]              cov_in;

   always_comb begin
      mid_s   = signed'(SW'(cfg.mid2));
      e0      = mid_s - SW'(ONE_FX);
      e1      = mid_s + SW'(ONE_FX);
      ramp    = RW'(e1 - a_s2_ff);
      ramp255 = (ramp <<< 8) - ramp + RW'(ONE_FX);
      if (a_s2_ff <= e0) begin
         cov_in = 8'd255;
      end else if (a_s2_ff >= e1) begin
         cov_in = 8'd0;
      end else begin
         cov_in = 8'(ramp255 >>> (GEOM_FRAC_BITS + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_dist_ff <= a_dist_ff;
         b_px_ff   <= a_px_ff;
         b_cov_ff  <= cov_in;
      end
   end

   // ---------------- stage C: coverage times colour alpha ----------------
   logic                    c_valid_ff;
   logic [DIST_W-1:0]       c_dist_ff;
   px_type                  c_px_ff;
   logic [15:0]             c_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_dist_ff <= b_dist_ff;
         c_px_ff   <= b_px_ff;
         c_x_ff    <= 16'(b_cov_ff) * 16'(cfg.color[7:0]) + 16'd127;
      end
   end

   // ---------------- stage D: divide by 255 through the reciprocal ----------
   logic                    d_valid_ff;
   logic [DIST_W-1:0]       d_dist_ff;
   px_type                  d_px_ff;
   logic [7:0]              d_a_ff;
   logic [31:0]             d_prod;

   assign d_prod = 32'(c_x_ff) * 32'(RECIP_255);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_dist_ff <= c_dist_ff;
         d_px_ff   <= c_px_ff;
         d_a_ff    <= d_prod[30:23];
      end
   end

   // ---------------- stage E: weights and denominator ----------------
   logic                    e_valid_ff;
   logic [DIST_W-1:0]       e_dist_ff;
   px_type                  e_px_ff;
   logic                    e_skip_ff;
   logic [15:0]             e_p_ff;
   logic [2:0][15:0]        e_q_ff;
   logic [15:0]             e_den_ff;
   logic [15:0]             p_in;
   logic [7:0]              inv_a;

   always_comb begin
      inv_a = 8'd255 - d_a_ff;
      p_in  = 16'(d_px_ff.alpha) * 16'(inv_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_dist_ff <= d_dist_ff;
         e_px_ff   <= d_px_ff;
         e_skip_ff <= !cfg.enable || (d_a_ff == 8'd0);
         e_p_ff    <= p_in;
         e_q_ff[0] <= 16'(d_a_ff) * 16'(cfg.color[15:8]);
         e_q_ff[1] <= 16'(d_a_ff) * 16'(cfg.color[23:16]);
         e_q_ff[2] <= 16'(d_a_ff) * 16'(cfg.color[31:24]);
         e_den_ff  <= {d_a_ff, 8'h00} - 16'(d_a_ff) + p_in;
      end
   end

   // ---------------- stage F: numerators, output alpha ----------------
   div_type                 div_ff [0:QW];
   logic [QW:0]             dv_ff;
   div_type                 f_in;
   logic [16:0]             den_r;
   logic [33:0]             oa_prod;
   logic [2:0][7:0]         d_chan;

   always_comb begin
      d_chan[0]  = e_px_ff.blue;
      d_chan[1]  = e_px_ff.green;
      d_chan[2]  = e_px_ff.red;
      den_r      = 17'(e_den_ff) + 17'd127;
      oa_prod    = 34'(den_r) * 34'(RECIP_255);
      f_in.px    = e_px_ff;
      f_in.rdist = e_dist_ff;
      f_in.skip  = e_skip_ff;
      f_in.oa    = oa_prod[30:23];
      f_in.den2  = {e_den_ff, 1'b0};
      for (int i = 0; i < 3; i++) begin
         // Rounded quotient: (2*num + den) / (2*den).
         f_in.rem[i] = ((NUM_W'({e_q_ff[i], 8'h00}) - NUM_W'(e_q_ff[i])
                        + NUM_W'(e_p_ff) * NUM_W'(d_chan[i])) << 1)
                       + NUM_W'(e_den_ff);
         f_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= f_in;
      end
   end

   // ---------------- restoring division, one quotient bit a stage ----------
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int SH = QW - 1 - k;
      div_type step_in;

      always_comb begin
         step_in = div_ff[k];
         for (int i = 0; i < 3; i++) begin
            if (div_ff[k].rem[i] >= (NUM_W'(div_ff[k].den2) << SH)) begin
               step_in.rem[i] = div_ff[k].rem[i] - (NUM_W'(div_ff[k].den2) << SH);
               step_in.quo[i] = {div_ff[k].quo[i][QW-2:0], 1'b1};
            end else begin
               step_in.quo[i] = {div_ff[k].quo[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= step_in;
         end
      end
   end

   // ---------------- output: clamp and select ----------------
   logic                    out_valid_ff;
   logic [DIST_W-1:0]       out_dist_ff;
   px_type                  out_px_ff;
   px_type                  px_in;
   logic [2:0][7:0]         chan_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan_in[i] = (div_ff[QW].quo[i] > QW'(255)) ? 8'd255 : div_ff[QW].quo[i][7:0];
      end
      if (div_ff[QW].skip) begin
         px_in = div_ff[QW].px;
      end else begin
         px_in.blue  = chan_in[0];
         px_in.green = chan_in[1];
         px_in.red   = chan_in[2];
         px_in.alpha = div_ff[QW].oa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_dist_ff <= div_ff[QW].rdist;
         out_px_ff   <= px_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_dist  = out_dist_ff;
   assign out_px    = out_px_ff;

   // Blending over never makes a pixel more transparent.
   a_alpha_grows: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QW] && !div_ff[QW].skip |-> div_ff[QW].oa >= div_ff[QW].px.alpha)
      else $error("aarc_blend: output alpha below destination alpha");

   // The rounded weighted mean of 8-bit colours stays within 8 bits.
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QW] && !div_ff[QW].skip |->
         div_ff[QW].quo[0] <= QW'(255) && div_ff[QW].quo[1] <= QW'(255)
         && div_ff[QW].quo[2] <= QW'(255))
      else $error("aarc_blend: blend quotient out of range");

endmodule
